FILE: hw/rtl/poslist_pkg.sv
`timescale 1ns / 1ps

package poslist_pkg;

  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // decoded action for one request
  typedef struct packed {
    status_t status;
    logic    do_ins;
    logic    do_del;
    logic    do_read;
  } ctl_t;

endpackage

FILE: hw/rtl/positional_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// start is registered into req_valid, and req_valid into the done strobe
// throughput: one request per cycle, busy is never raised
// stage one registers the request, stage two checks, shifts the store and
// registers the result; the parallel shift of every entry sets this rate
// reset clears the entry count and the strobes; store contents are left as is
// the receiver cannot stall: done marks each result for exactly one cycle
module positional_list_insert_delete_unit #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [poslist_pkg::POS_W-1:0] position,
  input  logic [poslist_pkg::VAL_W-1:0] value,
  output logic                          done,
  output logic [poslist_pkg::STAT_W-1:0] status,
  output logic [poslist_pkg::CNT_W-1:0] entries_now,
  output logic [poslist_pkg::VAL_W-1:0] read_value
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // request register
  logic                          req_valid;
  logic [1:0]                    req_mode;
  logic [poslist_pkg::POS_W-1:0] req_pos;
  logic [poslist_pkg::VAL_W-1:0] req_value;

  // list state
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  poslist_pkg::ctl_t     ctl;
  logic [IW-1:0]         slot;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] got;
  logic [63:0]           value_wide;
  logic [63:0]           got_wide;
  logic [poslist_pkg::VAL_W-1:0] read_value_next;
  logic [poslist_pkg::POS_W-1:0] slot_full;

  // never stalls the sender
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (start) begin
      req_mode  <= mode;
      req_pos   <= position;
      req_value <= value;
    end
  end

  // decode and range check against the current count
  poslist_check #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_check (
    .en       (req_valid),
    .mode     (req_mode),
    .position (req_pos),
    .count    (count),
    .ctl      (ctl)
  );

  // zero-based slot; only meaningful when the position passed the check
  assign slot_full  = req_pos - poslist_pkg::POS_W'(1);
  assign slot       = slot_full[IW-1:0];
  assign value_wide = 64'(req_value);
  assign word       = value_wide[DATA_WIDTH-1:0];

  poslist_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_store (
    .clk  (clk),
    .ctl  (ctl),
    .slot (slot),
    .word (word),
    .got  (got)
  );

  always_comb begin
    count_next = count;
    if (ctl.do_ins) begin
      count_next = count + CW'(1);
    end else if (ctl.do_del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // read word is zero unless a read or delete succeeded
  assign got_wide        = 64'(got);
  assign read_value_next = ctl.do_read ? got_wide[poslist_pkg::VAL_W-1:0]
                                       : '0;

  // result register: strobe for one cycle per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status      <= ctl.status;
      entries_now <= poslist_pkg::CNT_W'(count_next);
      read_value  <= read_value_next;
    end
  end

endmodule

FILE: hw/rtl/poslist_check.sv
`timescale 1ns / 1ps

module poslist_check #(
  parameter int DEPTH = 32,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                         en,
  input  logic [1:0]                   mode,
  input  logic [poslist_pkg::POS_W-1:0] position,
  input  logic [CW-1:0]                count,
  output poslist_pkg::ctl_t            ctl
);

  logic [7:0] pos8;
  logic [7:0] cnt8;
  logic       ins_pos_ok;
  logic       acc_pos_ok;
  logic       full;

  assign pos8       = 8'(position);
  assign cnt8       = 8'(count);
  assign ins_pos_ok = (pos8 != 8'd0) && (pos8 <= cnt8 + 8'd1);
  assign acc_pos_ok = (pos8 != 8'd0) && (pos8 <= cnt8);
  assign full       = (cnt8 >= 8'(DEPTH));

  always_comb begin
    ctl = '{status: poslist_pkg::STATUS_BADPOS, do_ins: 1'b0, do_del: 1'b0, do_read: 1'b0};
    unique case (poslist_pkg::mode_t'(mode))
      poslist_pkg::MODE_INSERT: begin
        if (!ins_pos_ok) begin
          ctl.status = poslist_pkg::STATUS_BADPOS;
        end else if (full) begin
          ctl.status = poslist_pkg::STATUS_FULL;
        end else begin
          ctl.status = poslist_pkg::STATUS_OK;
          ctl.do_ins = en;
        end
      end
      poslist_pkg::MODE_DELETE: begin
        if (acc_pos_ok) begin
          ctl.status  = poslist_pkg::STATUS_OK;
          ctl.do_del  = en;
          ctl.do_read = 1'b1;
        end
      end
      poslist_pkg::MODE_READ: begin
        if (acc_pos_ok) begin
          ctl.status  = poslist_pkg::STATUS_OK;
          ctl.do_read = 1'b1;
        end
      end
      default: begin
        ctl.status = poslist_pkg::STATUS_BADPOS;
      end
    endcase
  end

endmodule

FILE: hw/rtl/poslist_store.sv
`timescale 1ns / 1ps

module poslist_store #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  poslist_pkg::ctl_t     ctl,
  input  logic [IW-1:0]         slot,
  input  logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] got
);

  logic [DATA_WIDTH-1:0] entry [DEPTH];

  // entries at and above the slot shift in parallel
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctl.do_ins) begin
        if (IW'(i) == slot) begin
          entry[i] <= word;
        end else if ((i > 0) && (IW'(i) > slot)) begin
          entry[i] <= entry[(i > 0) ? i - 1 : 0];
        end
      end else if (ctl.do_del) begin
        if ((i < DEPTH - 1) && (IW'(i) >= slot)) begin
          entry[i] <= entry[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign got = entry[slot];

endmodule
